@@ hw/rtl/bdt_pkg.sv @@
`timescale 1ns / 1ps
// Package: shared types, codes and constants of the button debounce/toggle/hold core.
package bdt_pkg;

    // Buttons that have raw and mode bits on the ports
    localparam int WIRED_BUTTONS = 8;
    localparam int NUM_BUTTONS_DEF = 8;

    // Configuration reset values
    localparam logic [3:0]  ACTIVE_COUNT_RST = 4'd8;
    localparam logic [15:0] MODE_BITS_RST    = 16'd0;
    localparam logic [15:0] DEBOUNCE_MS_RST  = 16'd20;
    localparam logic [15:0] HOLD_THR_MS_RST  = 16'd1000;

    // held / 1000 == (held * SEC_RECIP) >> SEC_SHIFT for every 32-bit held
    localparam int          SEC_RECIP_W = 29;
    localparam logic [28:0] SEC_RECIP   = 29'd274877907;
    localparam int          SEC_SHIFT   = 38;
    localparam int          SEC_PROD_W  = 32 + SEC_RECIP_W;

    typedef enum logic [1:0] {
        MODE_IGNORE = 2'd0,
        MODE_ANALOG = 2'd1,
        MODE_DIRECT = 2'd2,
        MODE_TOGGLE = 2'd3
    } t_mode;

    typedef enum logic {
        ACT_SCAN  = 1'b0,
        ACT_CLEAR = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        CFG_ACTIVE_COUNT = 2'd0,
        CFG_MODE_BITS    = 2'd1,
        CFG_DEBOUNCE_MS  = 2'd2,
        CFG_HOLD_THR_MS  = 2'd3
    } t_cfg_reg;

    // What happens to the hold seconds byte when the transaction reaches the output
    typedef enum logic [1:0] {
        SECS_KEEP  = 2'd0,
        SECS_CLEAR = 2'd1,
        SECS_LOAD  = 2'd2
    } t_secs_op;

    // Per-button control from the top level for one transaction
    typedef struct packed {
        logic  step;   // transaction moves from the input register into the state stage
        logic  scan;   // button is scanned by this transaction
        logic  clear;  // button's toggle state is cleared by this transaction
        t_mode mode;
    } t_lane_ctl;

endpackage

@@ hw/rtl/bdt_lane.sv @@
`timescale 1ns / 1ps
// Module: state and update logic of one button, with the hold-seconds conversion stage.
module bdt_lane (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bdt_pkg::t_lane_ctl  i_ctl,
    input  logic                i_out_load,
    input  logic                i_raw,
    input  logic [31:0]         i_now,
    input  logic [15:0]         i_debounce_ms,
    input  logic [15:0]         i_hold_thr_ms,
    output logic                o_debounced,
    output logic                o_logical,
    output logic                o_hold_flag,
    output logic [7:0]          o_hold_secs
);

    logic                   r_raw_latch, n_raw_latch;
    logic [31:0]            r_change_time, n_change_time;
    logic                   r_debounced, n_debounced;
    logic                   r_logical, n_logical;
    logic                   r_hold_flag, n_hold_flag;
    logic [31:0]            r_hold_start, n_hold_start;
    logic [31:0]            r_held, n_held;
    bdt_pkg::t_secs_op      r_secs_op, n_secs_op;
    logic [7:0]             r_hold_secs;

    logic                   raw_chg;
    logic [31:0]            db_diff;
    logic                   db_ok;
    logic                   press;
    logic                   release_edge;
    logic [31:0]            held;
    logic                   hold_hit;
    logic [bdt_pkg::SEC_PROD_W-1:0] sec_prod;

    always_comb begin
        raw_chg       = (i_raw != r_raw_latch);
        n_raw_latch   = i_raw;
        n_change_time = raw_chg ? i_now : r_change_time;
        db_diff       = i_now - r_change_time;
        // a fresh change has zero stable time
        db_ok         = raw_chg ? (i_debounce_ms == 16'd0)
                                : (db_diff >= {16'd0, i_debounce_ms});
        n_debounced   = ((i_raw != r_debounced) && db_ok) ? i_raw : r_debounced;
        press         = n_debounced & ~r_debounced;
        release_edge  = ~n_debounced & r_debounced;
        held          = press ? 32'd0 : (i_now - r_hold_start);
        hold_hit      = (held >= {16'd0, i_hold_thr_ms});

        n_logical     = r_logical;
        n_hold_flag   = r_hold_flag;
        n_hold_start  = r_hold_start;
        n_held        = held;
        n_secs_op     = bdt_pkg::SECS_KEEP;

        if (i_ctl.scan) begin
            if (i_ctl.mode == bdt_pkg::MODE_DIRECT) begin
                n_logical = n_debounced;
            end else begin
                if (press) begin
                    n_logical    = ~r_logical;
                    n_hold_start = i_now;
                end
                if (n_debounced && hold_hit) begin
                    n_hold_flag = 1'b1;
                    n_secs_op   = bdt_pkg::SECS_LOAD;
                end else if (press || release_edge) begin
                    n_hold_flag = 1'b0;
                    n_secs_op   = bdt_pkg::SECS_CLEAR;
                end
            end
        end else if (i_ctl.clear) begin
            n_logical = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_raw_latch   <= 1'b0;
            r_change_time <= '0;
            r_debounced   <= 1'b0;
            r_logical     <= 1'b0;
            r_hold_flag   <= 1'b0;
            r_hold_start  <= '0;
            r_secs_op     <= bdt_pkg::SECS_KEEP;
        end else if (i_ctl.step) begin
            r_secs_op <= n_secs_op;
            if (i_ctl.scan) begin
                r_raw_latch   <= n_raw_latch;
                r_change_time <= n_change_time;
                r_debounced   <= n_debounced;
                r_hold_flag   <= n_hold_flag;
                r_hold_start  <= n_hold_start;
            end
            if (i_ctl.scan || i_ctl.clear) begin
                r_logical <= n_logical;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_held <= n_held;
        end
    end

    // Whole seconds by reciprocal multiply; keep the low byte
    assign sec_prod = r_held * bdt_pkg::SEC_RECIP;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold_secs <= '0;
        end else if (i_out_load) begin
            case (r_secs_op)
                bdt_pkg::SECS_LOAD:  r_hold_secs <= sec_prod[bdt_pkg::SEC_SHIFT +: 8];
                bdt_pkg::SECS_CLEAR: r_hold_secs <= '0;
                default:             r_hold_secs <= r_hold_secs;
            endcase
        end
    end

    assign o_debounced = r_debounced;
    assign o_logical   = r_logical;
    assign o_hold_flag = r_hold_flag;
    assign o_hold_secs = r_hold_secs;

endmodule

@@ hw/rtl/button_debounce_toggle_hold_core.sv @@
`timescale 1ns / 1ps
// Module: top level of the button debounce core with direct/toggle modes and hold detection.
//
// One transaction is either a scan of all buttons (timestamp plus raw pressed bits) or a
// clear of one toggle button's logical state; every transaction yields exactly one result
// with the logical, debounced, hold-flag and hold-seconds state after it. The core takes
// one transaction per clock while o_stall is low and passes it in order through an
// input register, a state stage where the debounce/toggle/hold state of each scanned
// or cleared button is updated (that per-button update is the loop that sets the rate), and
// an output register where the held time is turned into whole seconds by a reciprocal
// multiply. The output register and the pipeline stages let new transactions enter while
// a result waits; o_stall rises only when all stages are full and i_stall is high.
// Configuration writes are always ready and must be issued only while the core is idle.
// Timestamps wrap modulo 2^32. Buttons at or above the active count or NUM_BUTTONS,
// or in ignore/analog mode are left untouched.
module button_debounce_toggle_hold_core #(
    parameter int NUM_BUTTONS = bdt_pkg::NUM_BUTTONS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transaction channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_raw_pressed,
    input  logic [2:0]  i_target_button,
    // result channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_logical_state,
    output logic [7:0]  o_debounced_state,
    output logic [7:0]  o_hold_flags,
    output logic [63:0] o_hold_seconds,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    // Buttons with storage: limited by the parameter and by the wired port bits
    localparam int LANES = (NUM_BUTTONS < bdt_pkg::WIRED_BUTTONS) ?
                           NUM_BUTTONS : bdt_pkg::WIRED_BUTTONS;

    // Configuration registers
    logic [3:0]  r_active_count;
    logic [15:0] r_mode_bits;
    logic [15:0] r_debounce_ms;
    logic [15:0] r_hold_thr_ms;

    // Input register stage
    logic        r_s1_valid;
    logic        r_s1_action;
    logic [31:0] r_s1_now;
    logic [7:0]  r_s1_raw;
    logic [2:0]  r_s1_target;

    // State stage valid; its payload is the button state itself
    logic        r_s2_valid;

    // Output register
    logic        r_out_valid;
    logic [7:0]  r_out_logical;
    logic [7:0]  r_out_debounced;
    logic [7:0]  r_out_flags;

    logic        out_free;
    logic        s2_move;
    logic        s2_free;
    logic        s1_move;
    logic        s1_free;
    logic        in_take;

    logic [7:0]  lane_logical;
    logic [7:0]  lane_debounced;
    logic [7:0]  lane_flags;
    logic [63:0] lane_secs;

    // Advance each stage when the one after it has room
    always_comb begin
        out_free = !r_out_valid || !i_stall;
        s2_move  = r_s2_valid && out_free;
        s2_free  = !r_s2_valid || out_free;
        s1_move  = r_s1_valid && s2_free;
        s1_free  = !r_s1_valid || s2_free;
        in_take  = i_valid && s1_free;
    end

    assign o_stall     = !s1_free;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_count <= bdt_pkg::ACTIVE_COUNT_RST;
            r_mode_bits    <= bdt_pkg::MODE_BITS_RST;
            r_debounce_ms  <= bdt_pkg::DEBOUNCE_MS_RST;
            r_hold_thr_ms  <= bdt_pkg::HOLD_THR_MS_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (bdt_pkg::t_cfg_reg'(i_cfg_index))
                bdt_pkg::CFG_ACTIVE_COUNT: r_active_count <= i_cfg_data[3:0];
                bdt_pkg::CFG_MODE_BITS:    r_mode_bits    <= i_cfg_data;
                bdt_pkg::CFG_DEBOUNCE_MS:  r_debounce_ms  <= i_cfg_data;
                bdt_pkg::CFG_HOLD_THR_MS:  r_hold_thr_ms  <= i_cfg_data;
                default:                   r_active_count <= r_active_count;
            endcase
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s1_free) begin
                r_s1_valid <= i_valid;
            end
            if (s2_free) begin
                r_s2_valid <= s1_move;
            end
            if (out_free) begin
                r_out_valid <= s2_move;
            end
        end
    end

    // Capture the accepted transaction
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_s1_action <= i_action;
            r_s1_now    <= i_now_ms;
            r_s1_raw    <= i_raw_pressed;
            r_s1_target <= i_target_button;
        end
    end

    // Per-button lanes; positions without storage read as zero
    for (genvar gi = 0; gi < bdt_pkg::WIRED_BUTTONS; gi++) begin : g_lane
        if (gi < LANES) begin : g_used
            bdt_pkg::t_lane_ctl ctl;
            logic               active;

            always_comb begin
                active    = (r_active_count > 4'(gi));
                ctl.mode  = bdt_pkg::t_mode'(r_mode_bits[2*gi +: 2]);
                ctl.step  = s1_move;
                ctl.scan  = active && (r_s1_action == bdt_pkg::ACT_SCAN) &&
                            ((ctl.mode == bdt_pkg::MODE_DIRECT) ||
                             (ctl.mode == bdt_pkg::MODE_TOGGLE));
                ctl.clear = active && (r_s1_action == bdt_pkg::ACT_CLEAR) &&
                            (r_s1_target == 3'(gi)) &&
                            (ctl.mode == bdt_pkg::MODE_TOGGLE);
            end

            bdt_lane u_lane (
                .i_clk          (i_clk),
                .i_rst_n        (i_rst_n),
                .i_ctl          (ctl),
                .i_out_load     (s2_move),
                .i_raw          (r_s1_raw[gi]),
                .i_now          (r_s1_now),
                .i_debounce_ms  (r_debounce_ms),
                .i_hold_thr_ms  (r_hold_thr_ms),
                .o_debounced    (lane_debounced[gi]),
                .o_logical      (lane_logical[gi]),
                .o_hold_flag    (lane_flags[gi]),
                .o_hold_secs    (lane_secs[8*gi +: 8])
            );
        end else begin : g_none
            assign lane_debounced[gi]  = 1'b0;
            assign lane_logical[gi]    = 1'b0;
            assign lane_flags[gi]      = 1'b0;
            assign lane_secs[8*gi +: 8] = 8'd0;
        end
    end

    // Output register: copy the state left by the transaction in the state stage
    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_out_logical   <= lane_logical;
            r_out_debounced <= lane_debounced;
            r_out_flags     <= lane_flags;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_logical_state   = r_out_logical;
    assign o_debounced_state = r_out_debounced;
    assign o_hold_flags      = r_out_flags;
    // hold-seconds bytes load at the same edge as the output register
    assign o_hold_seconds    = lane_secs;

endmodule

@@ hw/rtl/bdt_checker.sv @@
`timescale 1ns / 1ps
// Module: port-level checker for the button debounce core, bound to the top level.
module bdt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_logical_state,
    input logic [7:0]  o_hold_flags,
    input logic [63:0] o_hold_seconds
);

    // A stalled result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_logical_state) &&
                                  $stable(o_hold_flags) && $stable(o_hold_seconds)))
        else $error("stalled result changed");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    // Nonzero hold seconds only come with a raised hold flag
    for (genvar gi = 0; gi < 8; gi++) begin : g_secs
        a_secs_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            (o_valid && (o_hold_seconds[8*gi +: 8] != 8'd0)) |-> o_hold_flags[gi])
            else $error("hold seconds without hold flag");
    end

endmodule

bind button_debounce_toggle_hold_core bdt_checker u_bdt_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_logical_state (o_logical_state),
    .o_hold_flags    (o_hold_flags),
    .o_hold_seconds  (o_hold_seconds)
);
